// File: design/wcb_pkg.sv
// ----------------------------------------------------------------------------
// wcb_pkg
// Shared types and codes for the watchdog counter bank.
// ----------------------------------------------------------------------------
package wcb_pkg;

	localparam int unsigned DEF_SLOTS      = 16;
	localparam int unsigned DEF_COUNT_BITS = 16;
	localparam logic [15:0] DEFAULT_RELOAD = 16'd100;

	typedef enum logic [1:0] {
		ACT_REGISTER = 2'd0,
		ACT_FEED     = 2'd1,
		ACT_QUERY    = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		EV_REGISTERED = 3'd0,
		EV_BANK_FULL  = 3'd1,
		EV_FED        = 3'd2,
		EV_STATUS     = 3'd3,
		EV_TIMEOUT    = 3'd4,
		EV_TICK_DONE  = 3'd5,
		EV_BAD_SLOT   = 3'd6
	} event_t;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_REG   = 3'd0,
		OP_FULL  = 3'd1,
		OP_FEED  = 3'd2,
		OP_QUERY = 3'd3,
		OP_BAD   = 3'd4,
		OP_TICK  = 3'd5
	} op_t;

	localparam int unsigned OP_W = $bits(op_t);

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [15:0] reload_value;
		logic        has_handler;
	} in_word_t;

	typedef struct packed {
		event_t      event_kind;
		logic [3:0]  slot_index;
		logic        online;
		logic        last;
	} out_word_t;

endpackage

// File: design/watchdog_counter_bank.sv
// ----------------------------------------------------------------------------
// watchdog_counter_bank
// Bank of watchdog channels with register, feed, query and tick commands.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; a two-word queue
// lets commands be taken while the back end is still working. Register, feed
// and query run through the idle state (slot memory read), then the exec state
// (update and result). A tick then walks the claimed slots, reading one slot a
// cycle through the counter memory's single read port. Each result is on result
// for one cycle with result_stb high and cannot be held off.
// ----------------------------------------------------------------------------
module watchdog_counter_bank #(
	parameter int unsigned SLOTS      = wcb_pkg::DEF_SLOTS,
	parameter int unsigned COUNT_BITS = wcb_pkg::DEF_COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  wcb_pkg::in_word_t  cmd,
	output logic               result_stb,
	output wcb_pkg::out_word_t result
);
	import wcb_pkg::*;

	localparam int unsigned Q_W = OP_W + 4 + COUNT_BITS + 1;

	logic                  push;
	logic                  pop;
	logic                  q_full;
	logic                  q_empty;
	op_t                   f_op;
	logic [3:0]            f_slot;
	logic [COUNT_BITS-1:0] f_reload;
	logic                  f_handler;
	logic [Q_W-1:0]        q_rdata;
	logic [OP_W-1:0]       b_op_bits;
	logic [3:0]            b_slot;
	logic [COUNT_BITS-1:0] b_reload;
	logic                  b_handler;

	assign busy = q_full;

	wcb_front #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.q_full  (q_full),
		.cmd     (cmd),
		.push    (push),
		.op      (f_op),
		.slot    (f_slot),
		.reload  (f_reload),
		.handler (f_handler)
	);

	wcb_queue #(
		.DATA_W (Q_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_op, f_slot, f_reload, f_handler}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_op_bits, b_slot, b_reload, b_handler} = q_rdata;

	wcb_back #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.op         (op_t'(b_op_bits)),
		.slot       (b_slot),
		.reload     (b_reload),
		.handler    (b_handler),
		.pop        (pop),
		.result_stb (result_stb),
		.result     (result)
	);

endmodule

// File: design/wcb_front.sv
// ----------------------------------------------------------------------------
// wcb_front
// Takes command words, tracks claimed slots and classifies each word.
// ----------------------------------------------------------------------------
module wcb_front #(
	parameter int unsigned SLOTS      = wcb_pkg::DEF_SLOTS,
	parameter int unsigned COUNT_BITS = wcb_pkg::DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  q_full,
	input  wcb_pkg::in_word_t     cmd,
	output logic                  push,
	output wcb_pkg::op_t          op,
	output logic [3:0]            slot,
	output logic [COUNT_BITS-1:0] reload,
	output logic                  handler
);
	import wcb_pkg::*;

	localparam int unsigned CNT_W = $clog2(SLOTS + 1);
	localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;
	localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

	logic [CNT_W-1:0] claimed_q;
	logic [15:0]      rl_fix;
	logic             bank_full;
	logic             slot_bad;

	assign push      = start && !q_full;
	assign bank_full = (claimed_q == CNT_W'(SLOTS));
	assign slot_bad  = (CMP_W'(cmd.slot) >= CMP_W'(claimed_q));
	assign rl_fix    = (cmd.reload_value == 16'd0) ? DEFAULT_RELOAD : cmd.reload_value;

	always_comb begin
		reload = ({17'd0, rl_fix} > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(rl_fix);
	end

	assign slot    = cmd.slot;
	assign handler = cmd.has_handler;

	always_comb begin
		case (action_t'(cmd.action))
			ACT_REGISTER: op = bank_full ? OP_FULL : OP_REG;
			ACT_FEED:     op = slot_bad ? OP_BAD : OP_FEED;
			ACT_QUERY:    op = slot_bad ? OP_BAD : OP_QUERY;
			ACT_TICK:     op = OP_TICK;
			default:      op = OP_TICK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
		end else if (push && op == OP_REG) begin
			claimed_q <= claimed_q + CNT_W'(1);
		end
	end

endmodule

// File: design/wcb_queue.sv
// ----------------------------------------------------------------------------
// wcb_queue
// Two-entry word queue between front and back.
// ----------------------------------------------------------------------------
module wcb_queue #(
	parameter int unsigned DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);
	logic [DATA_W-1:0] ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// File: design/wcb_back.sv
// ----------------------------------------------------------------------------
// wcb_back
// Executes classified words against the slot memories and drives results.
// ----------------------------------------------------------------------------
module wcb_back #(
	parameter int unsigned SLOTS      = wcb_pkg::DEF_SLOTS,
	parameter int unsigned COUNT_BITS = wcb_pkg::DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  wcb_pkg::op_t          op,
	input  logic [3:0]            slot,
	input  logic [COUNT_BITS-1:0] reload,
	input  logic                  handler,
	output logic                  pop,
	output logic                  result_stb,
	output wcb_pkg::out_word_t    result
);
	import wcb_pkg::*;

	localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [3:0]            slot_q;
	logic [COUNT_BITS-1:0] reload_q;
	logic                  handler_q;
	logic [CNT_W-1:0]      claimed_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      idx_nx;

	logic [COUNT_BITS-1:0] cd_mem [SLOTS];
	logic [COUNT_BITS-1:0] rl_mem [SLOTS];
	logic                  hf_mem [SLOTS];

	logic [SLOT_W-1:0]     rd_addr;
	logic [COUNT_BITS-1:0] cd_rd_s1;
	logic [COUNT_BITS-1:0] rl_rd_s1;
	logic                  hf_rd_s1;

	logic                  cd_we;
	logic                  cfg_we;
	logic [SLOT_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] cd_wdata;

	logic                  tick_end;
	logic                  emit;
	out_word_t             res_d;

	assign idx_nx   = idx_q + CNT_W'(1);
	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign tick_end = (idx_q == claimed_q);

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = (op == OP_TICK) ? '0 : SLOT_W'(slot);
		end else begin
			rd_addr = SLOT_W'(idx_nx);
		end
	end

	always_ff @(posedge clk) begin
		cd_rd_s1 <= cd_mem[rd_addr];
		rl_rd_s1 <= rl_mem[rd_addr];
		hf_rd_s1 <= hf_mem[rd_addr];
	end

	always_comb begin
		cd_we    = 1'b0;
		cfg_we   = 1'b0;
		wr_addr  = SLOT_W'(slot_q);
		cd_wdata = '0;
		emit     = 1'b0;
		res_d    = '{event_kind: EV_TICK_DONE, slot_index: 4'd0, online: 1'b0, last: 1'b1};
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_REG: begin
					cd_we            = 1'b1;
					cfg_we           = 1'b1;
					wr_addr          = SLOT_W'(claimed_q);
					emit             = 1'b1;
					res_d.event_kind = EV_REGISTERED;
					res_d.slot_index = 4'(claimed_q);
				end
				OP_FULL: begin
					emit             = 1'b1;
					res_d.event_kind = EV_BANK_FULL;
				end
				OP_FEED: begin
					cd_we            = 1'b1;
					cd_wdata         = rl_rd_s1;
					emit             = 1'b1;
					res_d.event_kind = EV_FED;
					res_d.slot_index = slot_q;
				end
				OP_QUERY: begin
					emit             = 1'b1;
					res_d.event_kind = EV_STATUS;
					res_d.slot_index = slot_q;
					res_d.online     = (cd_rd_s1 != '0);
				end
				OP_BAD: begin
					emit             = 1'b1;
					res_d.event_kind = EV_BAD_SLOT;
					res_d.slot_index = slot_q;
				end
				OP_TICK: begin
					wr_addr = SLOT_W'(idx_q);
					if (tick_end) begin
						emit = 1'b1;
					end else if (cd_rd_s1 != '0) begin
						cd_we    = 1'b1;
						cd_wdata = cd_rd_s1 - COUNT_BITS'(1);
					end else if (hf_rd_s1) begin
						emit             = 1'b1;
						res_d.event_kind = EV_TIMEOUT;
						res_d.slot_index = 4'(idx_q);
						res_d.last       = 1'b0;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cd_we) begin
			cd_mem[wr_addr] <= cd_wdata;
		end
		if (cfg_we) begin
			rl_mem[wr_addr] <= reload_q;
			hf_mem[wr_addr] <= handler_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q      <= op;
			slot_q    <= slot;
			reload_q  <= reload;
			handler_q <= handler;
		end
		if (emit) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			claimed_q  <= '0;
			idx_q      <= '0;
			result_stb <= 1'b0;
		end else begin
			result_stb <= emit;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_TICK && !tick_end) begin
						idx_q <= idx_nx;
					end else begin
						state_q <= S_IDLE;
					end
					if (op_q == OP_REG) begin
						claimed_q <= claimed_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_claimed_range: assert property (@(posedge clk) disable iff (!arst_n)
		claimed_q <= CNT_W'(SLOTS))
		else $error("claimed count beyond bank size");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= claimed_q)
		else $error("tick walk past claimed slots");

	a_timeout_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && !result.last |-> result.event_kind == EV_TIMEOUT)
		else $error("non-final word that is not a timeout");

	a_one_word_per_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && op_q != OP_TICK |=> state_q == S_IDLE && result_stb)
		else $error("single-word op did not finish in one step");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the watchdog counter bank.
// ----------------------------------------------------------------------------
// Command words go in on a start/busy handshake, with random bursts of idle
// cycles. A scoreboard keeps its own copy of the bank state (claimed slots,
// counters, reload values, handler flags) and works out the result words that
// each accepted command causes. Every strobed result word is checked, field by
// field, against the oldest one still awaited. A directed opening covers bad
// slots, the default reload, the widest reload, both handler settings, ticks
// with and without timeouts and a full bank. A random mix of register, feed,
// query and tick commands follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import wcb_pkg::*;

	localparam int unsigned RANDOM_WORDS = 150;
	localparam int unsigned QUIET_TAIL   = 30;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	class watchdog_scoreboard;
		int unsigned                  n_claimed;
		logic [DEF_COUNT_BITS-1:0]    countdown_q [DEF_SLOTS];
		logic [DEF_COUNT_BITS-1:0]    reload_q    [DEF_SLOTS];
		logic                         handler_q   [DEF_SLOTS];
		out_word_t                    awaited [$];
		int unsigned                  errors;

		function new();
			n_claimed = 0;
			errors    = 0;
			foreach (countdown_q[i]) begin
				countdown_q[i] = '0;
				reload_q[i]    = '0;
				handler_q[i]   = 1'b0;
			end
		endfunction

		function void await_word(event_t kind, logic [3:0] idx, logic on, logic fin);
			out_word_t w;
			w.event_kind = kind;
			w.slot_index = idx;
			w.online     = on;
			w.last       = fin;
			awaited.push_back(w);
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// predicted effect of one accepted command word
		function void note_word(in_word_t w);
			logic [DEF_COUNT_BITS-1:0] reload;
			case (w.action)
				ACT_REGISTER: begin
					if (n_claimed >= DEF_SLOTS) begin
						await_word(EV_BANK_FULL, 4'd0, 1'b0, 1'b1);
					end else begin
						reload = (w.reload_value == '0) ? DEFAULT_RELOAD : w.reload_value;
						reload_q[n_claimed]    = reload;
						handler_q[n_claimed]   = w.has_handler;
						countdown_q[n_claimed] = '0;
						await_word(EV_REGISTERED, n_claimed[3:0], 1'b0, 1'b1);
						n_claimed++;
					end
				end
				ACT_FEED, ACT_QUERY: begin
					if (w.slot >= n_claimed) begin
						await_word(EV_BAD_SLOT, w.slot, 1'b0, 1'b1);
					end else if (w.action == ACT_FEED) begin
						countdown_q[w.slot] = reload_q[w.slot];
						await_word(EV_FED, w.slot, 1'b0, 1'b1);
					end else begin
						await_word(EV_STATUS, w.slot, countdown_q[w.slot] != '0, 1'b1);
					end
				end
				default: begin
					for (int unsigned i = 0; i < n_claimed; i++) begin
						if (countdown_q[i] != '0)
							countdown_q[i] = countdown_q[i] - 1'b1;
						else if (handler_q[i])
							await_word(EV_TIMEOUT, i[3:0], 1'b0, 1'b0);
					end
					await_word(EV_TICK_DONE, 4'd0, 1'b0, 1'b1);
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(out_word_t got);
			out_word_t exp;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected word kind %0d slot %0d", got.event_kind,
					got.slot_index));
			end else begin
				exp = awaited.pop_front();
				if (got.event_kind !== exp.event_kind)
					report($sformatf("event_kind %0d, expected %0d", got.event_kind,
						exp.event_kind));
				if (got.slot_index !== exp.slot_index)
					report($sformatf("slot_index %0d, expected %0d (kind %0d)",
						got.slot_index, exp.slot_index, exp.event_kind));
				if (got.online !== exp.online)
					report($sformatf("online %0b, expected %0b (slot %0d)", got.online,
						exp.online, exp.slot_index));
				if (got.last !== exp.last)
					report($sformatf("last %0b, expected %0b (kind %0d)", got.last,
						exp.last, exp.event_kind));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  cmd;
	logic      result_stb;
	out_word_t result;

	watchdog_scoreboard sb;
	int unsigned        cycle_count;
	bit                 idle_on;

	watchdog_counter_bank dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.result_stb (result_stb),
		.result     (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_stb === 1'b1)
			sb.check_result(result);
	end

	task send_word(action_t act, logic [3:0] slot, logic [15:0] reload, logic handler);
		in_word_t    w;
		int unsigned gap;
		w.action       = act;
		w.slot         = slot;
		w.reload_value = reload;
		w.has_handler  = handler;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task send_random_word();
		int unsigned roll;
		logic [15:0] reload;
		roll   = $urandom_range(0, 99);
		reload = 16'($urandom_range(0, 65535));
		if (roll < 15) begin
			case ($urandom_range(0, 9))
				0:       reload = '0;
				1, 2, 3: reload = 16'($urandom_range(0, 65535));
				default: reload = 16'($urandom_range(1, 4));
			endcase
			send_word(ACT_REGISTER, 4'($urandom_range(0, 15)), reload,
				1'($urandom_range(0, 1)));
		end else if (roll < 45) begin
			send_word(ACT_FEED, 4'($urandom_range(0, 15)), reload,
				1'($urandom_range(0, 1)));
		end else if (roll < 68) begin
			send_word(ACT_QUERY, 4'($urandom_range(0, 15)), reload,
				1'($urandom_range(0, 1)));
		end else begin
			send_word(ACT_TICK, 4'($urandom_range(0, 15)), reload,
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		sb          = new();
		cycle_count = 0;
		idle_on     = 1'b1;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty bank: bad slots and a bare tick
		send_word(ACT_FEED,  4'd0,  16'hFFFF, 1'b1);
		send_word(ACT_QUERY, 4'd15, 16'h0000, 1'b0);
		send_word(ACT_TICK,  4'd0,  16'h0000, 1'b0);
		// default reload, shortest, widest
		send_word(ACT_REGISTER, 4'd9, 16'd0,     1'b1);
		send_word(ACT_REGISTER, 4'd0, 16'd1,     1'b0);
		send_word(ACT_REGISTER, 4'd0, 16'hFFFF,  1'b1);
		send_word(ACT_REGISTER, 4'd0, 16'd2,     1'b1);
		send_word(ACT_QUERY,    4'd1, 16'd0,     1'b0);
		send_word(ACT_FEED,     4'd3, 16'd0,     1'b0);
		send_word(ACT_FEED,     4'd0, 16'd0,     1'b0);
		send_word(ACT_QUERY,    4'd3, 16'd0,     1'b0);
		send_word(ACT_TICK,     4'd0, 16'd0,     1'b0);
		send_word(ACT_TICK,     4'd0, 16'd0,     1'b0);
		send_word(ACT_QUERY,    4'd3, 16'd0,     1'b0);
		send_word(ACT_TICK,     4'd0, 16'd0,     1'b0);
		send_word(ACT_FEED,     4'd4, 16'd0,     1'b1);
		send_word(ACT_QUERY,    4'd15, 16'd0,    1'b1);
		// fill the bank, then one too many
		for (int unsigned i = 4; i < DEF_SLOTS; i++)
			send_word(ACT_REGISTER, 4'd0, 16'($urandom_range(1, 3)), i[0]);
		send_word(ACT_REGISTER, 4'd0, 16'd5, 1'b1);
		send_word(ACT_TICK,     4'd0, 16'd0, 1'b0);

		for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
			if (n >= RANDOM_WORDS - QUIET_TAIL)
				idle_on = 1'b0;
			send_random_word();
		end
		@(negedge clk);
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
